// File: rtl/frsqrt_pkg.sv
// ----------------------------------------------------------------------------
// frsqrt_pkg: binary32 arithmetic for the vector normaliser
// Round-to-nearest-even multiply and add with IEEE special cases.
// ----------------------------------------------------------------------------
`default_nettype none
package frsqrt_pkg;

   localparam logic [31:0] RSQRT_MAGIC = 32'h5f3759df;
   localparam logic [31:0] F_HALF      = 32'h3f000000;
   localparam logic [31:0] F_THREE_HALF = 32'h3fc00000;
   localparam logic [31:0] F_DEFAULT_NAN = 32'hffc00000;
   localparam logic [31:0] F_QUIET_BIT = 32'h00400000;
   localparam int unsigned NUM_STAGES = 9;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } stage_type;

   function automatic logic is_nan(input logic [31:0] f);
      is_nan = (f[30:23] == 8'hff) && (f[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [31:0] f);
      is_inf = (f[30:23] == 8'hff) && (f[22:0] == 23'd0);
   endfunction

   function automatic logic is_zero(input logic [31:0] f);
      is_zero = (f[30:0] == 31'd0);
   endfunction

   // right shift of a 27-bit mantissa keeping a sticky bit
   function automatic logic [26:0] shr_sticky(input logic [26:0] m, input logic [11:0] sh);
      logic [26:0] r;
      logic        st;
      r  = 27'd0;
      st = 1'b0;
      if (sh >= 12'd27) begin
         st = |m;
      end else begin
         r  = m >> sh[4:0];
         st = |(m & ~(27'h7ffffff << sh[4:0]));
      end
      shr_sticky = {r[26:1], r[0] | st};
   endfunction

   // round and pack; m has its leading one at bit 26, three extra bits below
   function automatic logic [31:0] pack(input logic sgn, input logic signed [11:0] e,
                                        input logic [26:0] m);
      logic [26:0] mm;
      logic [7:0]  ef;
      logic        inc;
      logic [30:0] mag;
      mm = m;
      ef = 8'd0;
      if (e >= 12'sd255) begin
         pack = {sgn, 8'hff, 23'd0};
      end else begin
         if (e <= 12'sd0) begin
            mm = shr_sticky(m, 12'(12'sd1 - e));
         end else begin
            ef = e[7:0];
         end
         inc  = mm[2] & (mm[1] | mm[0] | mm[3]);
         mag  = {ef, mm[25:3]} + {30'd0, inc};
         pack = {sgn, mag};
      end
   endfunction

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      logic       found;
      n     = 6'd48;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (v[i] && !found) begin
            n     = 6'(47 - i);
            found = 1'b1;
         end
      end
      lzc48 = n;
   endfunction

   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      logic       found;
      n     = 5'd27;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (v[i] && !found) begin
            n     = 5'(26 - i);
            found = 1'b1;
         end
      end
      lzc27 = n;
   endfunction

   function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
      logic               sgn;
      logic [23:0]        ma, mb;
      logic [11:0]        ea, eb;
      logic [47:0]        p, pn;
      logic [5:0]         lz;
      logic signed [11:0] e;
      sgn = a[31] ^ b[31];
      ma  = {(a[30:23] != 8'd0), a[22:0]};
      mb  = {(b[30:23] != 8'd0), b[22:0]};
      ea  = (a[30:23] == 8'd0) ? 12'd1 : {4'd0, a[30:23]};
      eb  = (b[30:23] == 8'd0) ? 12'd1 : {4'd0, b[30:23]};
      p   = ma * mb;
      lz  = lzc48(p);
      pn  = p << lz;
      e   = $signed(ea + eb - 12'd126 - {6'd0, lz});
      if (is_nan(a)) begin
         fmul = a | F_QUIET_BIT;
      end else if (is_nan(b)) begin
         fmul = b | F_QUIET_BIT;
      end else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) begin
         fmul = F_DEFAULT_NAN;
      end else if (is_inf(a) || is_inf(b)) begin
         fmul = {sgn, 8'hff, 23'd0};
      end else if (is_zero(a) || is_zero(b)) begin
         fmul = {sgn, 31'd0};
      end else begin
         fmul = pack(sgn, e, {pn[47:22], |pn[21:0]});
      end
   endfunction

   // a + b, or a - b when neg_b is set
   function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b_in,
                                        input logic neg_b);
      logic [31:0]        b, big, sml;
      logic [11:0]        eb_big, eb_sml;
      logic [26:0]        m_big, m_sml;
      logic [27:0]        sum;
      logic [26:0]        m27;
      logic [4:0]         lz;
      logic signed [11:0] e;
      b      = is_nan(b_in) ? b_in : {b_in[31] ^ neg_b, b_in[30:0]};
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      eb_big = (big[30:23] == 8'd0) ? 12'd1 : {4'd0, big[30:23]};
      eb_sml = (sml[30:23] == 8'd0) ? 12'd1 : {4'd0, sml[30:23]};
      m_big  = {(big[30:23] != 8'd0), big[22:0], 3'b000};
      m_sml  = shr_sticky({(sml[30:23] != 8'd0), sml[22:0], 3'b000}, eb_big - eb_sml);
      if (big[31] == sml[31]) begin
         sum = {1'b0, m_big} + {1'b0, m_sml};
      end else begin
         sum = {1'b0, m_big} - {1'b0, m_sml};
      end
      lz = lzc27(sum[26:0]);
      if (sum[27]) begin
         m27 = {sum[27:2], sum[1] | sum[0]};
         e   = $signed(eb_big + 12'd1);
      end else begin
         m27 = sum[26:0] << lz;
         e   = $signed(eb_big - {7'd0, lz});
      end
      if (is_nan(a)) begin
         fadd = a | F_QUIET_BIT;
      end else if (is_nan(b)) begin
         fadd = b | F_QUIET_BIT;
      end else if (is_inf(a) && is_inf(b) && (a[31] != b[31])) begin
         fadd = F_DEFAULT_NAN;
      end else if (is_inf(a)) begin
         fadd = a;
      end else if (is_inf(b)) begin
         fadd = b;
      end else if (sum == 28'd0) begin
         // exact zero: negative only when both operands are negative
         fadd = {a[31] & b[31], 31'd0};
      end else begin
         fadd = pack(big[31], e, m27);
      end
   endfunction

endpackage
`default_nettype wire

// File: rtl/fast_rsqrt_vector_normalize.sv
// ----------------------------------------------------------------------------
// fast_rsqrt_vector_normalize: 3D vector normaliser
// Sum of squares, bit-trick reciprocal square root, one Newton step, scale.
// ----------------------------------------------------------------------------
// each stage holds one level of binary32 operations, the squares and scaling on all three components at once
// throughput: one vector per cycle while the response is not stalled, all stages advance together
// a stalled response holds the whole pipeline
// synchronous reset clears the stage valid bits only
`default_nettype none
module fast_rsqrt_vector_normalize (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_vec_x,
   input  wire logic [31:0] req_vec_y,
   input  wire logic [31:0] req_vec_z,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_unit_x,
   output logic [31:0]      rsp_unit_y,
   output logic [31:0]      rsp_unit_z
);

   localparam int unsigned NS = frsqrt_pkg::NUM_STAGES;

   frsqrt_pkg::stage_type stage_ff [NS];
   frsqrt_pkg::stage_type stage_in [NS];
   logic [NS-1:0]         valid_ff;
   logic [NS-1:0]         valid_in;
   logic                  advance;

   assign advance   = rsp_ready | ~valid_ff[NS-1];
   assign req_ready = advance;
   assign valid_in  = {valid_ff[NS-2:0], req_valid};

   always_comb begin
      stage_in[0] = stage_ff[0];
      for (int i = 1; i < NS; i++) begin
         stage_in[i] = stage_ff[i-1];
      end
      // squares
      stage_in[0].x = req_vec_x;
      stage_in[0].y = req_vec_y;
      stage_in[0].z = req_vec_z;
      stage_in[0].a = frsqrt_pkg::fmul(req_vec_x, req_vec_x);
      stage_in[0].b = frsqrt_pkg::fmul(req_vec_y, req_vec_y);
      stage_in[0].c = frsqrt_pkg::fmul(req_vec_z, req_vec_z);
      stage_in[1].a = frsqrt_pkg::fadd(stage_ff[0].a, stage_ff[0].b, 1'b0);
      stage_in[2].a = frsqrt_pkg::fadd(stage_ff[1].a, stage_ff[1].c, 1'b0);
      // half of s and the first estimate from the bit pattern
      stage_in[3].a = frsqrt_pkg::fmul(frsqrt_pkg::F_HALF, stage_ff[2].a);
      stage_in[3].c = frsqrt_pkg::RSQRT_MAGIC - {stage_ff[2].a[31], stage_ff[2].a[31:1]};
      stage_in[4].a = frsqrt_pkg::fmul(stage_ff[3].a, stage_ff[3].c);
      stage_in[5].a = frsqrt_pkg::fmul(stage_ff[4].a, stage_ff[4].c);
      stage_in[6].a = frsqrt_pkg::fadd(frsqrt_pkg::F_THREE_HALF, stage_ff[5].a, 1'b1);
      stage_in[7].a = frsqrt_pkg::fmul(stage_ff[6].c, stage_ff[6].a);
      // scale the components
      stage_in[8].a = frsqrt_pkg::fmul(stage_ff[7].x, stage_ff[7].a);
      stage_in[8].b = frsqrt_pkg::fmul(stage_ff[7].y, stage_ff[7].a);
      stage_in[8].c = frsqrt_pkg::fmul(stage_ff[7].z, stage_ff[7].a);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NS; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign rsp_valid  = valid_ff[NS-1];
   assign rsp_unit_x = stage_ff[NS-1].a;
   assign rsp_unit_y = stage_ff[NS-1].b;
   assign rsp_unit_z = stage_ff[NS-1].c;

   // a stalled response freezes the whole pipe
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while response stalled");

   // an accepted transaction lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> valid_ff[0])
      else $error("accepted transaction lost at stage zero");

   // a stall keeps the valid bits and the second-to-last stage in place
   assert property (@(posedge clock) disable iff (reset)
      (!advance) |=> ($stable(valid_ff) && $stable(stage_ff[NS-2])))
      else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the fast_rsqrt_vector_normalize vector normaliser
// Drives float32 vectors over the request channel with random gaps, predicts
// each normalised vector with an independent float32 model built on real
// arithmetic with explicit round-to-nearest-even, and checks every response
// transaction in order against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] QNAN       = 32'h7fc00000;
   localparam int          CYCLE_LIMIT = 400000;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } unit_vec_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_vec_x;
   logic [31:0] req_vec_y;
   logic [31:0] req_vec_z;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_unit_x;
   logic [31:0] rsp_unit_y;
   logic [31:0] rsp_unit_z;

   unit_vec_type pending_units[$];
   int           err_count;
   int           cycle_count;
   bit           no_gaps;

   fast_rsqrt_vector_normalize u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_vec_x  (req_vec_x),
      .req_vec_y  (req_vec_y),
      .req_vec_z  (req_vec_z),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_unit_x (rsp_unit_x),
      .rsp_unit_y (rsp_unit_y),
      .rsp_unit_z (rsp_unit_z)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- float32

   function automatic bit f32_is_nan(input logic [31:0] f);
      return (f[30:23] == 8'hff) && (f[22:0] != 23'd0);
   endfunction

   function automatic real f32_to_real(input logic [31:0] f);
      real mag;
      if (f[30:23] == 8'hff) begin
         if (f[22:0] != 23'd0) return $bitstoreal(64'h7ff8000000000000);
         return $bitstoreal({f[31], 11'h7ff, 52'd0});
      end
      if (f[30:23] == 8'd0) begin
         if (f[22:0] == 23'd0) return $bitstoreal({f[31], 63'd0});
         mag = real'(f[22:0]) * (2.0 ** (-149));
         return f[31] ? -mag : mag;
      end
      return $bitstoreal({f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'd0});
   endfunction

   // round an exact or doubly rounded value to float32, nearest even
   function automatic logic [31:0] real_to_f32(input real v);
      logic [63:0] d, m, kept, rem, half, full;
      int          e, sh;
      d = $realtobits(v);
      if (d[62:52] == 11'h7ff) begin
         if (d[51:0] != 52'd0) return QNAN;
         return {d[63], 8'hff, 23'd0};
      end
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      e  = int'(d[62:52]) - 1023 + 127;
      m  = {11'd0, 1'b1, d[51:0]};
      sh = 29 + ((e < 1) ? (1 - e) : 0);
      if (sh > 60) sh = 60;
      kept = m >> sh;
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
      if (e < 1) e = 1;
      full = (64'(e - 1) << 23) + kept;
      if (full >= 64'h7f800000) return {d[63], 8'hff, 23'd0};
      return {d[63], full[30:0]};
   endfunction

   function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
      if (f32_is_nan(a) || f32_is_nan(b)) return QNAN;
      return real_to_f32(f32_to_real(a) * f32_to_real(b));
   endfunction

   function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
      if (f32_is_nan(a) || f32_is_nan(b)) return QNAN;
      return real_to_f32(f32_to_real(a) + f32_to_real(b));
   endfunction

   function automatic logic [31:0] f32_sub(input logic [31:0] a, input logic [31:0] b);
      if (f32_is_nan(a) || f32_is_nan(b)) return QNAN;
      return real_to_f32(f32_to_real(a) - f32_to_real(b));
   endfunction

   function automatic unit_vec_type normalize_vec(input logic [31:0] x,
                                                  input logic [31:0] y,
                                                  input logic [31:0] z);
      unit_vec_type u;
      logic [31:0]  sq, half_sq, est, corr, scale;
      sq      = f32_add(f32_add(f32_mul(x, x), f32_mul(y, y)), f32_mul(z, z));
      half_sq = f32_mul(frsqrt_pkg::F_HALF, sq);
      // bit trick: arithmetic shift keeps the sign, subtraction wraps
      est     = frsqrt_pkg::RSQRT_MAGIC - {sq[31], sq[31:1]};
      corr    = f32_mul(f32_mul(half_sq, est), est);
      scale   = f32_mul(est, f32_sub(frsqrt_pkg::F_THREE_HALF, corr));
      u.x     = f32_mul(x, scale);
      u.y     = f32_mul(y, scale);
      u.z     = f32_mul(z, scale);
      return u;
   endfunction

   // --------------------------------------------------------------- checking

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("[%0t] mismatch on %s: expected %08h, got %08h", $realtime, field, want, got);
      err_count++;
   endtask

   // any NaN is accepted where a NaN is predicted
   function automatic bit unit_ok(input logic [31:0] want, input logic [31:0] got);
      if (f32_is_nan(want)) return f32_is_nan(got);
      return want === got;
   endfunction

   always @(posedge clock) begin
      unit_vec_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_units.push_back(normalize_vec(req_vec_x, req_vec_y, req_vec_z));
         if (rsp_valid && rsp_ready) begin
            if (pending_units.size() == 0) begin
               $display("[%0t] response transaction with nothing expected", $realtime);
               err_count++;
            end else begin
               want = pending_units.pop_front();
               if (!unit_ok(want.x, rsp_unit_x)) report_mismatch("unit_x", want.x, rsp_unit_x);
               if (!unit_ok(want.y, rsp_unit_y)) report_mismatch("unit_y", want.y, rsp_unit_y);
               if (!unit_ok(want.z, rsp_unit_z)) report_mismatch("unit_z", want.z, rsp_unit_z);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // response side back-pressure
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // -------------------------------------------------------------- stimulus

   // valid stays high into the next transaction when no gap follows
   task automatic send_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_vec_x <= x;
      req_vec_y <= y;
      req_vec_z <= z;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic idle_req();
      req_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_moderate();
      return {1'($urandom), 8'($urandom_range(100, 154)), 23'($urandom)};
   endfunction

   function automatic logic [31:0] rand_component();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return {1'($urandom), 31'd0};
      if (pick == 1) return {1'($urandom), 8'd0, 23'($urandom)};
      if (pick == 2) return {1'($urandom), 8'($urandom_range(1, 40)), 23'($urandom)};
      if (pick == 3) return {1'($urandom), 8'($urandom_range(200, 254)), 23'($urandom)};
      return rand_moderate();
   endfunction

   task automatic test_directed();
      send_vec(32'h00000000, 32'h00000000, 32'h00000000);   // zero vector
      send_vec(32'h80000000, 32'h00000000, 32'h80000000);   // signed zeros
      send_vec(32'h3f800000, 32'h00000000, 32'h00000000);
      send_vec(32'h00000000, 32'hbf800000, 32'h00000000);
      send_vec(32'h00000000, 32'h00000000, 32'h40400000);
      send_vec(32'h3f800000, 32'h3f800000, 32'h3f800000);
      send_vec(32'h40400000, 32'hc0800000, 32'h00000000);
      send_vec(32'h7f7fffff, 32'h7f7fffff, 32'hff7fffff);   // squares overflow
      send_vec(32'h00000001, 32'h80000001, 32'h00000001);   // squares underflow
      send_vec(32'h007fffff, 32'h00000000, 32'h00000000);
      send_vec(32'h1f800000, 32'h00000000, 32'h00000000);
      send_vec(32'h7f800000, 32'h00000000, 32'h00000000);   // infinity
      send_vec(32'hff800000, 32'h3f800000, 32'h7f800000);
      send_vec(32'h7fc00000, 32'h3f800000, 32'h00000000);   // quiet nan
      send_vec(32'hffc00001, 32'h00000000, 32'h00000000);   // nan with sign set
      send_vec(32'h7f800001, 32'hffffffff, 32'h80000000);   // signalling nan
      send_vec(32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_vec(32'h5f000000, 32'h00000000, 32'h00000000);
      send_vec(32'h3dcccccd, 32'hbe4ccccd, 32'h3e99999a);
   endtask

   task automatic test_raw_bits(input int n);
      repeat (n) send_vec($urandom, $urandom, $urandom);
   endtask

   task automatic test_realistic(input int n);
      repeat (n) send_vec(rand_component(), rand_component(), rand_component());
   endtask

   task automatic test_back_to_back(input int n);
      no_gaps = 1'b1;
      repeat (n) send_vec(rand_moderate(), rand_moderate(), rand_moderate());
      no_gaps = 1'b0;
   endtask

   task automatic test_drain_pause();
      test_realistic(30);
      idle_req();
      wait (pending_units.size() == 0);
      @(negedge clock);
      test_realistic(30);
   endtask

   initial begin
      err_count   = 0;
      cycle_count = 0;
      no_gaps     = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_vec_x   = 32'd0;
      req_vec_y   = 32'd0;
      req_vec_z   = 32'd0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_raw_bits(300);
      test_realistic(800);
      test_back_to_back(200);
      test_drain_pause();
      idle_req();

      wait (pending_units.size() == 0);
      repeat (30) @(posedge clock);
      if (err_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: filelist.f
rtl/frsqrt_pkg.sv
rtl/fast_rsqrt_vector_normalize.sv
tb/sv/tb_top.sv
